### hw/rtl/pnce_pkg.sv
// Shared constants, types and helpers for the periodic neighbor cell enumerator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package pnce_pkg;

    // Grid geometry
    localparam int AXIS_BITS = 8;                   // bits of one coordinate
    localparam int SIZE_W    = AXIS_BITS + 1;       // effective size, 1 .. 2^AXIS_BITS
    localparam int CFG_W     = 9;                   // size register width
    localparam int CMP_W     = (CFG_W > SIZE_W) ? CFG_W : SIZE_W;
    localparam int PLANE_W   = 2 * SIZE_W;          // size_x * size_y
    localparam int YTERM_W   = AXIS_BITS + SIZE_W;  // y * size_x
    localparam int ZTERM_W   = AXIS_BITS + PLANE_W; // z * plane

    // Input and result words
    localparam int IDX_W    = 24;
    localparam int ORD_W    = 5;
    localparam int RUN_LEN  = 27;
    localparam logic [ORD_W-1:0] LAST_ORD = ORD_W'(RUN_LEN - 1);

    // Configuration registers
    localparam int REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Z = 2'd2;
    localparam logic [CFG_W-1:0]     SIZE_RESET = 9'd16;

    // Divider: RADIX_BITS quotient bits per cycle
    localparam int RADIX_BITS = 3;
    localparam int DIV_STEPS  = IDX_W / RADIX_BITS;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // Queue depths
    localparam int CQ_DEPTH  = 2;
    localparam int CQ_PTR_W  = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W  = $clog2(CQ_DEPTH + 1);
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Effective grid seen by front and back
    typedef struct packed {
        logic [SIZE_W-1:0]  sx;
        logic [SIZE_W-1:0]  sy;
        logic [SIZE_W-1:0]  sz;
        logic [PLANE_W-1:0] plane;
    } geom_t;

    // Center cell handed from front to back
    typedef struct packed {
        logic [AXIS_BITS-1:0] x;
        logic [AXIS_BITS-1:0] y;
        logic [AXIS_BITS-1:0] z;
        logic                 bad;
    } center_t;

    // Zero reads as one, anything above 2^AXIS_BITS saturates
    function automatic logic [SIZE_W-1:0] effective_size(input logic [CFG_W-1:0] raw);
        logic [CMP_W-1:0] s;
        logic [CMP_W-1:0] cap;
        s   = CMP_W'(raw);
        cap = CMP_W'(1) << AXIS_BITS;
        if (s == '0)
            s = CMP_W'(1);
        if (s > cap)
            s = cap;
        return SIZE_W'(s);
    endfunction

endpackage

### hw/rtl/pnce_front.sv
// Front part: accepts a center index and splits it into x, y, z by three
// radix-8 divider passes. Depends on pnce_pkg.
`timescale 1ns / 1ps

module pnce_front
    import pnce_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [IDX_W-1:0] cell_index,
    input  geom_t            geom,
    input  logic             q_full,
    output logic             q_push,
    output center_t          q_data
);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_HOLD} state_t;

    localparam logic [1:0] PASS_X = 2'd0;
    localparam logic [1:0] PASS_Y = 2'd1;
    localparam logic [1:0] PASS_Z = 2'd2;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    state_t               state_reg;
    logic [1:0]           pass_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [IDX_W-1:0]     dvd_reg;
    logic [AXIS_BITS-1:0] rem_reg;
    center_t              cen_reg;

    logic [SIZE_W-1:0]    divisor;
    logic [IDX_W-1:0]     dvd_step;
    logic [AXIS_BITS-1:0] rem_step;
    logic                 accept;

    // Divisor of the current pass
    always_comb
    begin
        case (pass_reg)
            PASS_X:  divisor = geom.sx;
            PASS_Y:  divisor = geom.sy;
            default: divisor = geom.sz;
        endcase
    end

    // Restoring division, RADIX_BITS quotient bits per cycle
    always_comb
    begin
        logic [SIZE_W-1:0]    t;
        logic [AXIS_BITS-1:0] r;
        logic [IDX_W-1:0]     d;
        r = rem_reg;
        d = dvd_reg;
        for (int i = 0; i < RADIX_BITS; i++)
        begin
            t = {r, d[IDX_W-1]};
            d = {d[IDX_W-2:0], 1'b0};
            if (t >= divisor)
            begin
                t    = t - divisor;
                d[0] = 1'b1;
            end
            r = AXIS_BITS'(t);
        end
        rem_step = r;
        dvd_step = d;
    end

    // Handshakes: a new word may enter in the cycle the finished one leaves
    assign q_push = (state_reg == S_HOLD) && !q_full;
    assign full   = !((state_reg == S_IDLE) || q_push);
    assign accept = push && !full;
    assign q_data = cen_reg;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass_reg  <= PASS_X;
            step_reg  <= '0;
            dvd_reg   <= '0;
            rem_reg   <= '0;
            cen_reg   <= '0;
        end
        else if (accept)
        begin
            state_reg <= S_DIV;
            pass_reg  <= PASS_X;
            step_reg  <= '0;
            dvd_reg   <= cell_index;
            rem_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_DIV:
                begin
                    dvd_reg <= dvd_step;
                    rem_reg <= rem_step;
                    if (step_reg == STEP_LAST)
                    begin
                        // quotient stays as next dividend, remainder restarts
                        step_reg <= '0;
                        rem_reg  <= '0;
                        case (pass_reg)
                            PASS_X:
                            begin
                                cen_reg.x <= rem_step;
                                pass_reg  <= PASS_Y;
                            end
                            PASS_Y:
                            begin
                                cen_reg.y <= rem_step;
                                pass_reg  <= PASS_Z;
                            end
                            default:
                            begin
                                // nonzero quotient: index beyond the grid
                                cen_reg.z   <= rem_step;
                                cen_reg.bad <= |dvd_step;
                                state_reg   <= S_HOLD;
                            end
                        endcase
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                S_HOLD:
                begin
                    if (q_push)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Checks
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_DIV) && (pass_reg == PASS_X) && (step_reg == '0))
        else $error("front: accepted word did not start a division");

    a_pass_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (pass_reg == PASS_X || pass_reg == PASS_Y ||
                                  pass_reg == PASS_Z))
        else $error("front: pass counter out of range");

    a_hold_after_z: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(state_reg == S_HOLD) |-> ($past(pass_reg) == PASS_Z) &&
                                       ($past(step_reg) == STEP_LAST))
        else $error("front: hand-off before the z pass finished");

endmodule

### hw/rtl/pnce_cmd_queue.sv
// Short queue of center cells between front and back parts.
// Depends on pnce_pkg.
`timescale 1ns / 1ps

module pnce_cmd_queue
    import pnce_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr,
    input  center_t wr_data,
    output logic    full,
    input  logic    rd,
    output center_t rd_data,
    output logic    empty
);

    center_t             mem [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg;
    logic [CQ_PTR_W-1:0] rd_ptr_reg;
    logic [CQ_CNT_W-1:0] cnt_reg;

    logic do_wr;
    logic do_rd;

    assign full    = (cnt_reg == CQ_CNT_W'(CQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            case ({do_wr, do_rd})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

### hw/rtl/pnce_back.sv
// Back part: walks the 27 offsets of one center, wraps each axis, forms the
// linear index in a three-stage pipeline and queues the results. Depends on pnce_pkg.
`timescale 1ns / 1ps

module pnce_back
    import pnce_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  geom_t            geom,
    input  logic             q_empty,
    output logic             q_pop,
    input  center_t          q_data,
    output logic             empty,
    input  logic             pop,
    output logic [IDX_W-1:0] neighbor_index,
    output logic [ORD_W-1:0] offset_ordinal,
    output logic             bad_index,
    output logic             last
);

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [ORD_W-1:0] ord;
        logic             bad;
        logic             last;
    } result_t;

    localparam logic [1:0] STEP_MINUS = 2'd0;
    localparam logic [1:0] STEP_PLUS  = 2'd2;

    // Coordinate plus step-1, wrapped into [0, s)
    function automatic logic [AXIS_BITS-1:0] wrap_axis(
        input logic [AXIS_BITS-1:0] c,
        input logic [1:0]           step,
        input logic [SIZE_W-1:0]    s
    );
        logic [SIZE_W-1:0] up;
        up = SIZE_W'(c) + 1'b1;
        case (step)
            STEP_MINUS: return (c == '0) ? AXIS_BITS'(s - 1'b1) : c - 1'b1;
            STEP_PLUS:  return (up == s) ? '0 : AXIS_BITS'(up);
            default:    return c;
        endcase
    endfunction

    // Run walker
    logic             active_reg;
    center_t          cen_reg;
    logic [1:0]       ix_reg;
    logic [1:0]       iy_reg;
    logic [1:0]       iz_reg;
    logic [ORD_W-1:0] ord_reg;

    // Pipeline stages
    logic                 a_valid_reg;
    logic [AXIS_BITS-1:0] a_nx_reg;
    logic [AXIS_BITS-1:0] a_ny_reg;
    logic [AXIS_BITS-1:0] a_nz_reg;
    logic [ORD_W-1:0]     a_ord_reg;
    logic                 a_bad_reg;
    logic                 a_last_reg;

    logic                 b_valid_reg;
    logic [AXIS_BITS-1:0] b_x_reg;
    logic [YTERM_W-1:0]   b_y_reg;
    logic [ZTERM_W-1:0]   b_z_reg;
    logic [ORD_W-1:0]     b_ord_reg;
    logic                 b_bad_reg;
    logic                 b_last_reg;

    // Result queue
    result_t              fifo_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg;
    logic [OUT_PTR_W-1:0] rd_ptr_reg;
    logic [OUT_CNT_W-1:0] cnt_reg;

    logic                 issue;
    logic                 issue_last;
    logic                 load;
    logic                 do_rd;
    logic [OUT_CNT_W:0]   committed;
    result_t              wr_word;
    result_t              rd_word;

    // Credit: queued plus in-flight words must leave room for one more
    assign committed  = (OUT_CNT_W + 1)'(cnt_reg) + (OUT_CNT_W + 1)'(a_valid_reg)
                      + (OUT_CNT_W + 1)'(b_valid_reg);
    assign issue      = active_reg && (committed < (OUT_CNT_W + 1)'(OUT_DEPTH));
    assign issue_last = issue && (ord_reg == LAST_ORD);
    assign load       = (!active_reg || issue_last) && !q_empty;
    assign q_pop      = load;

    // Walker: x outermost, z innermost
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            cen_reg    <= '0;
            ix_reg     <= '0;
            iy_reg     <= '0;
            iz_reg     <= '0;
            ord_reg    <= '0;
        end
        else if (load)
        begin
            active_reg <= 1'b1;
            cen_reg    <= q_data;
            ix_reg     <= '0;
            iy_reg     <= '0;
            iz_reg     <= '0;
            ord_reg    <= '0;
        end
        else if (issue_last)
        begin
            active_reg <= 1'b0;
        end
        else if (issue)
        begin
            ord_reg <= ord_reg + 1'b1;
            if (iz_reg == STEP_PLUS)
            begin
                iz_reg <= '0;
                if (iy_reg == STEP_PLUS)
                begin
                    iy_reg <= '0;
                    ix_reg <= ix_reg + 1'b1;
                end
                else
                begin
                    iy_reg <= iy_reg + 1'b1;
                end
            end
            else
            begin
                iz_reg <= iz_reg + 1'b1;
            end
        end
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= issue;
            b_valid_reg <= a_valid_reg;
        end
    end

    // Stage A: wrapped coordinates; stage B: axis terms
    always_ff @(posedge clk)
    begin
        a_nx_reg   <= wrap_axis(cen_reg.x, ix_reg, geom.sx);
        a_ny_reg   <= wrap_axis(cen_reg.y, iy_reg, geom.sy);
        a_nz_reg   <= wrap_axis(cen_reg.z, iz_reg, geom.sz);
        a_ord_reg  <= ord_reg;
        a_bad_reg  <= cen_reg.bad;
        a_last_reg <= (ord_reg == LAST_ORD);

        b_x_reg    <= a_nx_reg;
        b_y_reg    <= YTERM_W'(a_ny_reg) * YTERM_W'(geom.sx);
        b_z_reg    <= ZTERM_W'(a_nz_reg) * ZTERM_W'(geom.plane);
        b_ord_reg  <= a_ord_reg;
        b_bad_reg  <= a_bad_reg;
        b_last_reg <= a_last_reg;
    end

    // Stage C: sum, kept to the index width
    assign wr_word.index = IDX_W'(b_x_reg) + IDX_W'(b_y_reg) + IDX_W'(b_z_reg);
    assign wr_word.ord   = b_ord_reg;
    assign wr_word.bad   = b_bad_reg;
    assign wr_word.last  = b_last_reg;

    always_ff @(posedge clk)
    begin
        if (b_valid_reg)
            fifo_mem[wr_ptr_reg] <= wr_word;
    end

    // Result queue control
    assign empty = (cnt_reg == '0);
    assign do_rd = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (b_valid_reg)
                wr_ptr_reg <= (wr_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            case ({b_valid_reg, do_rd})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    // Head word
    assign rd_word        = fifo_mem[rd_ptr_reg];
    assign neighbor_index = rd_word.index;
    assign offset_ordinal = rd_word.ord;
    assign bad_index      = rd_word.bad;
    assign last           = rd_word.last;

    // Checks
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= OUT_CNT_W'(OUT_DEPTH))
        else $error("back: result queue count beyond depth");

    a_credit_room: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg |-> (cnt_reg < OUT_CNT_W'(OUT_DEPTH)))
        else $error("back: pipeline word arrived at a full result queue");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(active_reg) |-> $past(issue_last))
        else $error("back: run stopped before its last offset");

endmodule

### hw/rtl/periodic_neighbor_cell_enumerator_core.sv
// Top level of the periodic neighbor cell enumerator: size registers and
// geometry, front divider, center queue and back emitter. Depends on pnce_pkg.
`timescale 1ns / 1ps

// Each word pushed is a linear cell index (x fastest); the block returns 27
// words, the neighbor indices with periodic wrap, x offset outermost and z
// innermost, the 27th marked by last, bad_index set on the whole run when the
// index lies beyond the grid. The front splits the index with a radix-8
// divider in three passes, one per axis, and takes a new word when idle or
// as the finished one leaves for the center queue; the back emits one result
// per cycle while the result queue has room for it. A two-entry center queue
// and a four-entry result queue let both sides stall on their own.
// Size registers may only be written while the block is idle.
module periodic_neighbor_cell_enumerator_core
    import pnce_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 wr_en,
    input  logic [REG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data,
    // input queue side
    input  logic                 push,
    output logic                 full,
    input  logic [IDX_W-1:0]     cell_index,
    // result queue side
    output logic                 empty,
    input  logic                 pop,
    output logic [IDX_W-1:0]     neighbor_index,
    output logic [ORD_W-1:0]     offset_ordinal,
    output logic                 bad_index,
    output logic                 last
);

    logic [CFG_W-1:0]   size_x_reg;
    logic [CFG_W-1:0]   size_y_reg;
    logic [CFG_W-1:0]   size_z_reg;
    logic [PLANE_W-1:0] plane_reg;
    geom_t              geom;

    logic    cq_push;
    logic    cq_full;
    center_t cq_wr_data;
    logic    cq_pop;
    logic    cq_empty;
    center_t cq_rd_data;

    // Size registers; unknown index is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= SIZE_RESET;
            size_y_reg <= SIZE_RESET;
            size_z_reg <= SIZE_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_SIZE_X: size_x_reg <= wr_data;
                REG_SIZE_Y: size_y_reg <= wr_data;
                REG_SIZE_Z: size_z_reg <= wr_data;
                default:    ;
            endcase
        end
    end

    // Effective sizes and registered plane size
    assign geom.sx    = effective_size(size_x_reg);
    assign geom.sy    = effective_size(size_y_reg);
    assign geom.sz    = effective_size(size_z_reg);
    assign geom.plane = plane_reg;

    always_ff @(posedge clk)
    begin
        plane_reg <= PLANE_W'(geom.sx) * PLANE_W'(geom.sy);
    end

    pnce_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .cell_index (cell_index),
        .geom       (geom),
        .q_full     (cq_full),
        .q_push     (cq_push),
        .q_data     (cq_wr_data)
    );

    pnce_cmd_queue u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (cq_push),
        .wr_data (cq_wr_data),
        .full    (cq_full),
        .rd      (cq_pop),
        .rd_data (cq_rd_data),
        .empty   (cq_empty)
    );

    pnce_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .geom           (geom),
        .q_empty        (cq_empty),
        .q_pop          (cq_pop),
        .q_data         (cq_rd_data),
        .empty          (empty),
        .pop            (pop),
        .neighbor_index (neighbor_index),
        .offset_ordinal (offset_ordinal),
        .bad_index      (bad_index),
        .last           (last)
    );

endmodule

### bench/periodic_neighbor_cell_enumerator_core_test.sv
// Self-checking bench for periodic_neighbor_cell_enumerator_core: directed rows, then random
// grids and center words, each checked against an in-bench neighbor predictor.
// Depends on pnce_pkg and the core RTL only.
`timescale 1ns / 1ps

module periodic_neighbor_cell_enumerator_core_test;
    import pnce_pkg::*;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;   // no register behind this index
    localparam int MAX_REPORTS       = 10;
    localparam int DRAIN_CYCLES      = 40;                // extra wait after the last expected word
    localparam int WATCHDOG_LIMIT    = 3000;
    localparam int RANDOM_PHASES     = 8;
    localparam int CENTERS_PER_PHASE = 22;
    localparam int GRID_CAP          = 1 << AXIS_BITS;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [IDX_W-1:0] neighbor;
        logic [ORD_W-1:0] ordinal;
        logic             bad;
        logic             last;
    } neighbor_word_t;

    typedef struct {
        bit                   is_write;
        logic [REG_IDX_W-1:0] reg_sel;
        logic [CFG_W-1:0]     value;
        logic [IDX_W-1:0]     center;
        bit                   has_exp;
        logic [IDX_W-1:0]     exp_first;
        bit                   exp_bad;
    } stim_row_t;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             wr_en      = 1'b0;
    logic [REG_IDX_W-1:0] wr_index = '0;
    logic [CFG_W-1:0] wr_data    = '0;
    logic             push       = 1'b0;
    logic [IDX_W-1:0] cell_index = '0;
    logic             pop        = 1'b0;
    logic             full;
    logic             empty;
    logic [IDX_W-1:0] neighbor_index;
    logic [ORD_W-1:0] offset_ordinal;
    logic             bad_index;
    logic             last;

    // Predictor state: raw size registers as the block holds them
    logic [CFG_W-1:0] size_reg [3];

    neighbor_word_t pending_neighbors [$];
    stim_row_t      directed_rows [$];

    int send_idle_pct     = 0;
    int pop_stall_pct     = 0;
    int idle_cycles       = 0;
    int mismatches        = 0;
    int neighbors_checked = 0;
    int centers_sent      = 0;
    int centers_settled   = 0;
    int reg_writes        = 0;

    periodic_neighbor_cell_enumerator_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .push           (push),
        .full           (full),
        .cell_index     (cell_index),
        .empty          (empty),
        .pop            (pop),
        .neighbor_index (neighbor_index),
        .offset_ordinal (offset_ordinal),
        .bad_index      (bad_index),
        .last           (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Zero reads as one, anything past the axis range saturates
    function automatic int unsigned grid_extent(input logic [CFG_W-1:0] raw);
        int unsigned s;
        s = raw;
        if (s == 0)
            s = 1;
        if (s > GRID_CAP)
            s = GRID_CAP;
        return s;
    endfunction

    // Append the 27 wrapped neighbor words of one center, x outermost, z innermost
    function automatic void enumerate_neighbors(input logic [IDX_W-1:0] center);
        longint unsigned sx, sy, sz, plane, total, idx, cx, cy, cz, nx, ny, nz;
        neighbor_word_t  w;
        int              ord;
        sx    = grid_extent(size_reg[REG_SIZE_X]);
        sy    = grid_extent(size_reg[REG_SIZE_Y]);
        sz    = grid_extent(size_reg[REG_SIZE_Z]);
        idx   = center;
        plane = sx * sy;
        total = plane * sz;
        cx    = idx % sx;
        cy    = (idx / sx) % sy;
        cz    = (idx / plane) % sz;   // beyond-grid index: quotient wrapped into z range
        ord   = 0;
        for (int dx = 0; dx < 3; dx++)
            for (int dy = 0; dy < 3; dy++)
                for (int dz = 0; dz < 3; dz++)
                begin
                    nx = (cx + sx - 1 + dx) % sx;
                    ny = (cy + sy - 1 + dy) % sy;
                    nz = (cz + sz - 1 + dz) % sz;
                    w.neighbor = IDX_W'(nx + ny * sx + nz * plane);
                    w.ordinal  = ORD_W'(ord);
                    w.bad      = (idx >= total);
                    w.last     = (ord == RUN_LEN - 1);
                    pending_neighbors.push_back(w);
                    ord++;
                end
    endfunction

    function automatic void add_write(input logic [REG_IDX_W-1:0] sel,
                                      input logic [CFG_W-1:0] value);
        stim_row_t row;
        row = '{1'b1, sel, value, '0, 1'b0, '0, 1'b0};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_center(input logic [IDX_W-1:0] center, input bit has_exp,
                                       input logic [IDX_W-1:0] first, input bit bad);
        stim_row_t row;
        row = '{1'b0, REG_UNUSED, '0, center, has_exp, first, bad};
        directed_rows.push_back(row);
    endfunction

    // Mostly small grids, with the extremes and out-of-range register values mixed in
    function automatic logic [CFG_W-1:0] pick_size();
        case ($urandom_range(9))
            0:       return '0;
            1:       return CFG_W'(1);
            2:       return CFG_W'(GRID_CAP);
            3:       return CFG_W'($urandom_range(511, GRID_CAP + 1));
            4:       return CFG_W'($urandom_range(GRID_CAP, 2));
            default: return CFG_W'($urandom_range(12, 2));
        endcase
    endfunction

    function automatic void report_mismatch(input string what, input neighbor_word_t want,
                                            input neighbor_word_t seen);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $write("%0t %s: expected idx=%h ord=%0d bad=%b last=%b",
                   $time, what, want.neighbor, want.ordinal, want.bad, want.last);
            $display(", got idx=%h ord=%0d bad=%b last=%b",
                     seen.neighbor, seen.ordinal, seen.bad, seen.last);
        end
    endfunction

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  pop_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 69; pop_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  pop_stall_pct = 69; end
            default:       begin send_idle_pct = 9;  pop_stall_pct = 9;  end
        endcase
    endtask

    // Drop push, wait out every expected word plus the pipeline tail
    task automatic wait_for_idle();
        @(negedge clk);
        push = 1'b0;
        if (centers_sent != centers_settled)
        begin
            while (pending_neighbors.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
            centers_settled = centers_sent;
        end
    endtask

    task automatic write_size(input logic [REG_IDX_W-1:0] sel, input logic [CFG_W-1:0] value);
        wait_for_idle();
        @(negedge clk);
        wr_en    = 1'b1;
        wr_index = sel;
        wr_data  = value;
        @(negedge clk);
        wr_en = 1'b0;
        if (sel != REG_UNUSED)
            size_reg[sel] = value;
        reg_writes++;
    endtask

    // Offer one center word; predict its run at the accepting edge
    task automatic send_center(input logic [IDX_W-1:0] center, input bit has_exp,
                               input logic [IDX_W-1:0] exp_first, input bit exp_bad);
        int             base;
        neighbor_word_t w;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push       = 1'b1;
        cell_index = center;
        do
            @(posedge clk);
        while (full);
        base = pending_neighbors.size();
        enumerate_neighbors(center);
        // hand-computed first neighbor and flag override the predictor on directed rows
        if (has_exp)
            for (int k = 0; k < RUN_LEN; k++)
            begin
                w     = pending_neighbors[base + k];
                w.bad = exp_bad;
                if (k == 0)
                    w.neighbor = exp_first;
                pending_neighbors[base + k] = w;
            end
        centers_sent++;
    endtask

    // Receiver side: random pop stalls
    always @(negedge clk)
        pop <= ($urandom_range(99) >= pop_stall_pct);

    // Result checker
    always @(posedge clk)
    begin : check_results
        neighbor_word_t seen;
        neighbor_word_t want;
        if (rst_n && pop && !empty)
        begin
            seen = {neighbor_index, offset_ordinal, bad_index, last};
            neighbors_checked++;
            if (pending_neighbors.size() == 0)
                report_mismatch("word with nothing expected", '0, seen);
            else
            begin
                want = pending_neighbors.pop_front();
                if (seen.neighbor !== want.neighbor || seen.ordinal !== want.ordinal ||
                    seen.bad !== want.bad || seen.last !== want.last)
                    report_mismatch("neighbor word", want, seen);
            end
        end
    end

    // Watchdog: cycles with no word moving on either side
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned      total;
        logic [IDX_W-1:0] center;
        stim_row_t        row;
        int               directed_centers;
        size_reg[REG_SIZE_X] = SIZE_RESET;
        size_reg[REG_SIZE_Y] = SIZE_RESET;
        size_reg[REG_SIZE_Z] = SIZE_RESET;

        // Reset grid 16x16x16: corners, just past the grid, all ones
        add_center(24'h000000, 1'b1, 24'h000FFF, 1'b0);
        add_center(24'h000FFF, 1'b1, 24'h000EEE, 1'b0);
        add_center(24'h001000, 1'b1, 24'h000FFF, 1'b1);
        add_center(24'hFFFFFF, 1'b1, 24'h000EEE, 1'b1);
        add_center(24'h000123, 1'b0, '0, 1'b0);
        // zero sizes read as a 1x1x1 grid
        add_write(REG_SIZE_X, 9'd0);
        add_write(REG_SIZE_Y, 9'd0);
        add_write(REG_SIZE_Z, 9'd0);
        add_center(24'h000000, 1'b1, 24'h000000, 1'b0);
        add_center(24'h000001, 1'b1, 24'h000000, 1'b1);
        // full 256^3 grid: every index valid, wrap at the top of each axis
        add_write(REG_SIZE_X, 9'd256);
        add_write(REG_SIZE_Y, 9'd256);
        add_write(REG_SIZE_Z, 9'd256);
        add_center(24'h000000, 1'b1, 24'hFFFFFF, 1'b0);
        add_center(24'hFFFFFF, 1'b1, 24'hFEFEFE, 1'b0);
        // oversized registers saturate to 256
        add_write(REG_SIZE_X, 9'd511);
        add_write(REG_SIZE_Y, 9'd300);
        add_write(REG_SIZE_Z, 9'd257);
        add_center(24'h00ABCD, 1'b0, '0, 1'b0);
        // unknown register index leaves the grid alone
        add_write(REG_UNUSED, 9'd5);
        add_center(24'h000000, 1'b1, 24'hFFFFFF, 1'b0);
        // skewed 1x256x3 grid
        add_write(REG_SIZE_X, 9'd1);
        add_write(REG_SIZE_Y, 9'd256);
        add_write(REG_SIZE_Z, 9'd3);
        add_center(24'h000000, 1'b0, '0, 1'b0);
        add_center(24'h0002FF, 1'b0, '0, 1'b0);
        add_center(24'h000300, 1'b1, 24'h0002FF, 1'b1);
        // size 2: both offsets land on the same cell
        add_write(REG_SIZE_X, 9'd2);
        add_write(REG_SIZE_Y, 9'd2);
        add_write(REG_SIZE_Z, 9'd2);
        add_center(24'h000007, 1'b0, '0, 1'b0);
        add_center(24'h000008, 1'b0, '0, 1'b0);
        add_center(24'h800001, 1'b0, '0, 1'b0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part
        set_idling(IDLE_NONE);
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.is_write)
                write_size(row.reg_sel, row.value);
            else
                send_center(row.center, row.has_exp, row.exp_first, row.exp_bad);
        end
        directed_centers = centers_sent;

        // Random part: new grid per phase, idle mode rotates
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_size(REG_SIZE_X, pick_size());
            write_size(REG_SIZE_Y, pick_size());
            write_size(REG_SIZE_Z, pick_size());
            write_size(REG_UNUSED, CFG_W'($urandom_range(511)));
            set_idling(idle_mode_t'(phase % 4));
            total = grid_extent(size_reg[REG_SIZE_X]) * grid_extent(size_reg[REG_SIZE_Y]) *
                    grid_extent(size_reg[REG_SIZE_Z]);
            for (int n = 0; n < CENTERS_PER_PHASE; n++)
            begin
                // mostly cells inside the grid, some raw 24-bit words
                if ($urandom_range(4) == 0)
                    center = IDX_W'($urandom);
                else
                    center = IDX_W'($urandom_range(total - 1));
                send_center(center, 1'b0, '0, 1'b0);
            end
        end

        wait_for_idle();
        $display("Sent %0d center words (%0d directed), %0d register writes, %0d neighbor words",
                 centers_sent, directed_centers, reg_writes, neighbors_checked);
        $display("Idle phases: none, sender 69%%, receiver 69%%, both 9%%; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && pending_neighbors.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
